/* src/firl_pkg.sv */
// shared constants and types for the fir filter with loadable taps
`timescale 1ns / 1ps
package firl_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 18;
    localparam int CFG_BITS     = 7;
    localparam int IDX_BITS     = 6;
    localparam int TAP_CNT_BITS = $clog2(MAX_TAPS) + 1;
    localparam int FRAC_BITS    = COEF_BITS - 1;
    localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS     = PROD_BITS + $clog2(MAX_TAPS) + 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    typedef enum logic [1:0] {
        X_HOLD,
        X_DOWN,
        X_UP
    } x_op_t;

    typedef struct packed {
        x_op_t x_op;
        logic  c_down;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_MAC,
        ST_RESTORE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

/* src/firl_cell.sv */
// one tap cell: a delay line sample and a coefficient on two rings
`timescale 1ns / 1ps
module firl_cell
    import firl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  sample_t   x_lo,
    input  sample_t   x_hi,
    input  coef_t     c_hi,
    input  logic      c_wr,
    input  coef_t     c_wdata,
    output sample_t   x_q,
    output coef_t     c_q
);

    sample_t x_reg;
    coef_t   c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            c_reg <= '0;
        end else begin
            case (ctl.x_op)
                X_DOWN:  x_reg <= x_hi;
                X_UP:    x_reg <= x_lo;
                default: x_reg <= x_reg;
            endcase
            if (c_wr) begin
                c_reg <= c_wdata;
            end else if (ctl.c_down) begin
                c_reg <= c_hi;
            end
        end
    end

    assign x_q = x_reg;
    assign c_q = c_reg;

endmodule

/* src/firl_mac.sv */
// multiply-accumulate with rounding and saturation to the sample width
`timescale 1ns / 1ps
module firl_mac
    import firl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    clear,
    input  logic    en,
    input  sample_t x_in,
    input  coef_t   c_in,
    output sample_t result
);

    localparam logic signed [ACC_BITS-1:0] ROUND_ADD =
        {{(ACC_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_vld_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  rnd;
    logic signed [ACC_BITS-1:0]  shf;

    assign prod_next = x_in * c_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
    end

    always_comb begin
        rnd = acc_reg + ROUND_ADD;
        shf = rnd >>> FRAC_BITS;
        if (shf > SAT_HI) begin
            result = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shf < SAT_LO) begin
            result = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            result = shf[SAMPLE_BITS-1:0];
        end
    end

endmodule

/* src/fir_filter_loadable_taps_unit.sv */
// top level: fir filter with a loadable coefficient store on a ring of tap cells
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      s_mode, s_sample, s_coef_index, s_coef_value
//   m_        out        m_valid / m_ready      m_filtered
//   cfg_      in         cfg_wr_en              cfg_wr_data (tap count)
//
// a coefficient word is written to its cell as it is taken; a sample word goes through
// these steps: the delay ring turns to align, each tap feeds the one multiplier in
// turn, the coefficient ring turns home, then a drain state and an output state
// reset clears the delay line and the coefficients and sets the tap count to 64
// a waiting result holds only the final state; no words, coefficient words too, are taken until idle
`timescale 1ns / 1ps
module fir_filter_loadable_taps_unit
    import firl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  sample_t             s_sample,
    input  logic [IDX_BITS-1:0] s_coef_index,
    input  coef_t               s_coef_value,
    output logic                m_valid,
    input  logic                m_ready,
    output sample_t             m_filtered
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [CFG_BITS-1:0]     tap_count_reg;
    logic [TAP_CNT_BITS-1:0] n_reg;
    logic [TAP_CNT_BITS-1:0] n_next;
    logic [TAP_CNT_BITS-1:0] n_eff;
    logic [TAP_CNT_BITS-1:0] step_reg;
    logic [TAP_CNT_BITS-1:0] step_next;
    sample_t                 sample_reg;
    sample_t                 filtered_reg;
    logic                    m_valid_reg;

    logic      in_acc;
    logic      last_mac;
    logic      mac_en;
    logic      load_out;
    cell_ctl_t ctl;
    sample_t   mac_result;

    sample_t x_q  [MAX_TAPS];
    coef_t   c_q  [MAX_TAPS];
    sample_t x_lo [MAX_TAPS];
    sample_t x_hi [MAX_TAPS];
    coef_t   c_hi [MAX_TAPS];
    logic    c_wr [MAX_TAPS];

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_acc     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_filtered = filtered_reg;

    always_comb begin
        if (tap_count_reg == '0) begin
            n_eff = TAP_CNT_BITS'(1);
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            n_eff = TAP_CNT_BITS'(MAX_TAPS);
        end else begin
            n_eff = TAP_CNT_BITS'(tap_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= CFG_BITS'(MAX_TAPS);
            n_reg         <= '0;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            step_reg  <= step_next;
            if (cfg_wr_en) begin
                tap_count_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && !s_mode) begin
            sample_reg <= s_sample;
        end
        if (load_out) begin
            filtered_reg <= mac_result;
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        ctl.x_op   = X_HOLD;
        ctl.c_down = 1'b0;
        mac_en     = 1'b0;
        last_mac   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && !s_mode) begin
                    n_next    = n_eff;
                    step_next = '0;
                    if (n_eff == TAP_CNT_BITS'(1)) begin
                        state_next = ST_MAC;
                    end else begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN: begin
                ctl.x_op  = X_DOWN;
                step_next = step_reg + 1'b1;
                if (step_reg == n_reg - TAP_CNT_BITS'(2)) begin
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                ctl.x_op   = X_UP;
                ctl.c_down = 1'b1;
                mac_en     = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == n_reg - 1'b1) begin
                    last_mac  = 1'b1;
                    step_next = '0;
                    if (n_reg == TAP_CNT_BITS'(MAX_TAPS)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        state_next = ST_RESTORE;
                    end
                end
            end
            ST_RESTORE: begin
                ctl.c_down = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == TAP_CNT_BITS'(MAX_TAPS) - n_reg - 1'b1) begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring wiring: down takes from the next cell, up from the previous one
    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign x_lo[k] = last_mac ? sample_reg : x_q[MAX_TAPS-1];
            end else begin : g_body
                assign x_lo[k] = x_q[k-1];
            end
            if (k == MAX_TAPS - 1) begin : g_tail
                assign x_hi[k] = x_q[0];
                assign c_hi[k] = c_q[0];
            end else begin : g_inner
                assign x_hi[k] = x_q[k+1];
                assign c_hi[k] = c_q[k+1];
            end
            assign c_wr[k] = in_acc && s_mode && (32'(s_coef_index) == k);

            firl_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .x_lo    (x_lo[k]),
                .x_hi    (x_hi[k]),
                .c_hi    (c_hi[k]),
                .c_wr    (c_wr[k]),
                .c_wdata (s_coef_value),
                .x_q     (x_q[k]),
                .c_q     (c_q[k])
            );
        end
    endgenerate

    firl_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (in_acc && !s_mode),
        .en      (mac_en),
        .x_in    (x_q[0]),
        .c_in    (c_q[0]),
        .result  (mac_result)
    );

endmodule
